FILE: rtl/core/mwmad_pkg.sv
// ----------------------------------------------------------------------------
// mwmad_pkg
// Shared types, codes and tables of the moving-window MAD anomaly scorer.
// ----------------------------------------------------------------------------
package mwmad_pkg;

    // Quotient bits of the ratio (Q3.16 floor, below 8.0)
    localparam int Q_W = 19;

    // Configuration register indexes
    localparam logic CFG_IDX_THRESHOLD = 1'b0;
    localparam logic CFG_IDX_WINDOW    = 1'b1;

    // Item opcodes
    localparam logic OP_TRAIN = 1'b0;
    localparam logic OP_SCORE = 1'b1;

    // Full-scale score, 1.0 in Q1.15
    localparam logic [15:0] SCORE_ONE = 16'd32768;

    // Ratio at which the tanh table saturates, 6.0 in Q3.16
    localparam logic [Q_W-1:0] RATIO_SAT = 19'd393216;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TR_CHECK,
        ST_TR_EVICT,
        ST_TR_APPEND,
        ST_SC_MX,
        ST_SC_E,
        ST_SC_ACC,
        ST_SC_EN,
        ST_SC_TD,
        ST_SC_DEN,
        ST_SC_DIV,
        ST_SC_TM,
        ST_SC_TF,
        ST_SC_UPD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic done;
        logic sat;
    } div_status_t;

    // tanh at steps of 0.25 from 0 to 6, Q1.15
    function automatic logic [15:0] tanh_lut(input logic [4:0] idx);
        logic [15:0] val;
        unique case (idx)
            5'd0:    val = 16'd0;
            5'd1:    val = 16'd8025;
            5'd2:    val = 16'd15143;
            5'd3:    val = 16'd20813;
            5'd4:    val = 16'd24956;
            5'd5:    val = 16'd27797;
            5'd6:    val = 16'd29660;
            5'd7:    val = 16'd30847;
            5'd8:    val = 16'd31589;
            5'd9:    val = 16'd32048;
            5'd10:   val = 16'd32329;
            5'd11:   val = 16'd32501;
            5'd12:   val = 16'd32606;
            5'd13:   val = 16'd32670;
            5'd14:   val = 16'd32708;
            5'd15:   val = 16'd32732;
            5'd16:   val = 16'd32746;
            5'd17:   val = 16'd32755;
            5'd18:   val = 16'd32760;
            5'd19:   val = 16'd32763;
            5'd20:   val = 16'd32765;
            5'd21:   val = 16'd32766;
            5'd22:   val = 16'd32767;
            5'd23:   val = 16'd32767;
            default: val = 16'd32768;
        endcase
        return val;
    endfunction

endpackage

FILE: rtl/core/mwmad_ring_mem.sv
// ----------------------------------------------------------------------------
// mwmad_ring_mem
// Sample store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mwmad_ring_mem #(
    parameter int ADDR_W = 12
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [31:0]       wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [31:0]       rd_data
);

    logic [31:0] mem [2**ADDR_W];
    logic [31:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/mwmad_mul.sv
// ----------------------------------------------------------------------------
// mwmad_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mwmad_mul #(
    parameter int A_W = 59,
    parameter int B_W = 17
) (
    input  logic                    aclk,
    input  logic signed [A_W-1:0]   op_a,
    input  logic signed [B_W-1:0]   op_b,
    output logic signed [A_W+B_W-1:0] prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    // Register the product
    always_ff @(posedge aclk) begin
        prod_reg <= (A_W+B_W)'(op_a) * (A_W+B_W)'(op_b);
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/mwmad_div.sv
// ----------------------------------------------------------------------------
// mwmad_div
// Restoring divider, one quotient bit per cycle, with overflow detect.
// ----------------------------------------------------------------------------
module mwmad_div #(
    parameter int NUM_W = 82,
    parameter int DEN_W = 75
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [NUM_W-1:0]              num,
    input  logic [DEN_W-1:0]              den,
    output mwmad_pkg::div_status_t        status,
    output logic [mwmad_pkg::Q_W-1:0]     quot
);
    import mwmad_pkg::*;

    localparam int SHW  = DEN_W + Q_W;
    localparam int XW   = (NUM_W > SHW) ? NUM_W : SHW;
    localparam int STPW = $clog2(Q_W + 1);

    logic             busy_reg;
    logic [STPW-1:0]  step_reg;
    logic [NUM_W-1:0] rem_reg;
    logic [SHW-1:0]   dsh_reg;
    logic [Q_W-1:0]   q_reg;
    logic             done_reg;
    logic             sat_reg;
    logic             ge;

    assign ge = XW'(rem_reg) >= XW'(dsh_reg);

    // Control: start, step count, done pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STPW'(1);
                if ((step_reg == '0 && ge) || step_reg == STPW'(Q_W)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: compare, subtract, shift
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= {den, Q_W'(0)};
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end else if (busy_reg) begin
            dsh_reg <= dsh_reg >> 1;
            if (step_reg == '0) begin
                sat_reg <= ge;
            end else begin
                q_reg <= {q_reg[Q_W-2:0], ge};
                if (ge) begin
                    rem_reg <= NUM_W'(XW'(rem_reg) - XW'(dsh_reg));
                end
            end
        end
    end

    assign status.done = done_reg;
    assign status.sat  = sat_reg;
    assign quot        = q_reg;

endmodule

FILE: rtl/core/moving_window_mad_anomaly_score_core.sv
// ----------------------------------------------------------------------------
// moving_window_mad_anomaly_score_core
// Per-metric sliding windows with a MAD-based tanh anomaly score per event.
// ----------------------------------------------------------------------------
//  Channel | Ports                       | Dir | Handshake
//  --------+-----------------------------+-----+------------------
//  cfg     | cfg_wr_en/cfg_addr/wdata    | in  | write enable only
//  input   | s_valid/s_ready/s_*         | in  | valid/ready
//  result  | m_valid/m_ready/m_*         | out | valid/ready
//
//  Train item: evicts the oldest sample (memory read, subtract) while the window
//  is full, then appends. Score item: the window walk streams one sample per
//  cycle through the memory port and the shared multiplier, then the divider
//  runs an overflow check and 19 quotient bits, one per cycle; an item that
//  closes the event then passes the emit step.
//  Reset is synchronous; the sample store is not cleared.
//  A result waiting at the output stalls only the next emitting item.
// ----------------------------------------------------------------------------
module moving_window_mad_anomaly_score_core #(
    parameter int NUM_METRICS = 16,
    parameter int WINDOW_MAX  = 256,
    parameter int MIN_HISTORY = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [0:0]         cfg_addr,
    input  logic [15:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [3:0]         s_metric_index,
    input  logic signed [31:0] s_metric_value,
    input  logic               s_has_metric,
    input  logic               s_last_in_event,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_anomaly_score
);
    import mwmad_pkg::*;

    localparam int MW  = (NUM_METRICS > 1) ? $clog2(NUM_METRICS) : 1;
    localparam int SW  = $clog2(WINDOW_MAX);
    localparam int CW  = $clog2(WINDOW_MAX + 1);
    localparam int TW  = 32 + CW;
    localparam int EW  = 33 + CW;
    localparam int AW  = EW + CW;
    localparam int MA  = AW + 1;
    localparam int MB  = 17;
    localparam int PW  = MA + MB;
    localparam int NW  = EW + CW + 24;
    localparam int DW  = AW + 16;
    localparam int RAW = MW + SW;

    state_t state_reg, state_next;

    // Configuration
    logic [15:0] thr_reg;
    logic [8:0]  wlen_reg;
    logic [CW-1:0] eff_len;

    // Per-metric window state
    logic signed [TW-1:0] total_reg  [NUM_METRICS];
    logic [CW-1:0]        count_reg  [NUM_METRICS];
    logic [SW-1:0]        oldest_reg [NUM_METRICS];

    // Captured item
    logic               op_reg;
    logic [3:0]         metric_reg;
    logic signed [31:0] x_reg;
    logic               has_reg;
    logic               last_reg;
    logic [MW-1:0]      idx;
    logic               metric_ok;

    // Scoring datapath
    logic [EW-1:0]  e_reg;
    logic [AW-1:0]  a_reg;
    logic [NW-1:0]  num_reg;
    logic [CW-1:0]  rd_cnt_reg;
    logic [SW-1:0]  slot_reg;
    logic           v1_reg;
    logic           v2_reg;
    logic [15:0]    score_reg;
    logic [15:0]    max_reg;

    // Output register
    logic        m_valid_reg;
    logic [15:0] m_score_reg;

    // Shared units
    logic signed [MA-1:0] mul_a;
    logic signed [MB-1:0] mul_b;
    logic signed [PW-1:0] prod;
    logic                 div_start;
    div_status_t          div_st;
    logic [Q_W-1:0]       quot;
    logic                 mem_we;
    logic [RAW-1:0]       mem_waddr;
    logic [RAW-1:0]       mem_raddr;
    logic [31:0]          mem_rdata;

    // Helpers
    logic signed [TW-1:0] cur_total;
    logic [CW-1:0]        cur_count;
    logic [SW-1:0]        cur_oldest;
    logic [SW-1:0]        oldest_adv;
    logic [SW-1:0]        slot_adv;
    logic [CW:0]          app_sum;
    logic [SW-1:0]        app_slot;
    logic signed [PW-1:0] dev;
    logic [EW-1:0]        dev_abs;
    logic                 acc_issue;
    logic                 out_free;
    logic [4:0]           t_idx;
    logic [15:0]          t_lo;
    logic [15:0]          t_diff;
    logic [30:0]          t_round;
    logic                 sc_special;

    assign idx        = MW'(metric_reg);
    assign metric_ok  = has_reg && (32'(metric_reg) < NUM_METRICS);
    assign cur_total  = total_reg[idx];
    assign cur_count  = count_reg[idx];
    assign cur_oldest = oldest_reg[idx];

    // Clamp window length to 1..WINDOW_MAX
    always_comb begin
        if (wlen_reg == 9'd0) begin
            eff_len = CW'(1);
        end else if (32'(wlen_reg) > WINDOW_MAX) begin
            eff_len = CW'(WINDOW_MAX);
        end else begin
            eff_len = CW'(wlen_reg);
        end
    end

    assign oldest_adv = (cur_oldest == SW'(WINDOW_MAX - 1)) ? '0 : cur_oldest + SW'(1);
    assign slot_adv   = (slot_reg == SW'(WINDOW_MAX - 1)) ? '0 : slot_reg + SW'(1);
    assign app_sum    = (CW+1)'(cur_oldest) + (CW+1)'(cur_count);
    assign app_slot   = (32'(app_sum) >= WINDOW_MAX) ? SW'(app_sum - (CW+1)'(WINDOW_MAX))
                                                     : SW'(app_sum);

    // Absolute deviation of the product from the window total
    assign dev       = prod - PW'(cur_total);
    assign dev_abs   = dev[PW-1] ? EW'(-dev) : EW'(dev);
    assign acc_issue = (rd_cnt_reg != cur_count);
    assign out_free  = !m_valid_reg || m_ready;

    // tanh interpolation terms
    assign t_idx   = quot[Q_W-1:14];
    assign t_lo    = tanh_lut(t_idx);
    assign t_diff  = tanh_lut(t_idx + 5'd1) - t_lo;
    assign t_round = 31'(prod[29:0]) + 31'd8192;

    assign sc_special = (a_reg == '0) || (thr_reg == 16'd0);

    // Memory port selection
    assign mem_we    = (state_reg == ST_TR_APPEND);
    assign mem_waddr = {idx, app_slot};
    assign mem_raddr = (state_reg == ST_SC_ACC) ? {idx, slot_reg} : {idx, cur_oldest};

    // Multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_SC_MX: begin
                mul_a = MA'(x_reg);
                mul_b = MB'(cur_count);
            end
            ST_SC_ACC: begin
                mul_a = MA'($signed(mem_rdata));
                mul_b = MB'(cur_count);
            end
            ST_SC_EN: begin
                mul_a = MA'(e_reg);
                mul_b = MB'(cur_count);
            end
            ST_SC_TD: begin
                mul_a = MA'(a_reg);
                mul_b = MB'(thr_reg);
            end
            ST_SC_TM: begin
                mul_a = MA'(t_diff);
                mul_b = MB'(quot[13:0]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign div_start = (state_reg == ST_SC_DEN) && !sc_special;

    // Sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (op_reg == OP_TRAIN) begin
                    state_next = metric_ok ? ST_TR_CHECK : ST_IDLE;
                end else if (metric_ok && (32'(cur_count) >= MIN_HISTORY)
                             && (cur_count != '0)) begin
                    state_next = ST_SC_MX;
                end else begin
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_TR_CHECK:  state_next = (cur_count >= eff_len) ? ST_TR_EVICT : ST_TR_APPEND;
            ST_TR_EVICT:  state_next = ST_TR_CHECK;
            ST_TR_APPEND: state_next = ST_IDLE;
            ST_SC_MX:     state_next = ST_SC_E;
            ST_SC_E:      state_next = (dev_abs == '0) ? ST_SC_UPD : ST_SC_ACC;
            ST_SC_ACC: begin
                if (!acc_issue && !v1_reg && !v2_reg) begin
                    state_next = ST_SC_EN;
                end
            end
            ST_SC_EN:     state_next = ST_SC_TD;
            ST_SC_TD:     state_next = ST_SC_DEN;
            ST_SC_DEN:    state_next = sc_special ? ST_SC_UPD : ST_SC_DIV;
            ST_SC_DIV: begin
                if (div_st.done) begin
                    state_next = div_st.sat ? ST_SC_UPD : ST_SC_TM;
                end
            end
            ST_SC_TM:     state_next = (quot >= RATIO_SAT) ? ST_SC_UPD : ST_SC_TF;
            ST_SC_TF:     state_next = ST_SC_UPD;
            ST_SC_UPD:    state_next = last_reg ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= 16'd768;
            wlen_reg <= 9'd100;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IDX_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_IDX_WINDOW:    wlen_reg <= cfg_wdata[8:0];
                default:           thr_reg  <= thr_reg;
            endcase
        end
    end

    // Capture the item on transfer
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            op_reg     <= s_opcode;
            metric_reg <= s_metric_index;
            x_reg      <= s_metric_value;
            has_reg    <= s_has_metric;
            last_reg   <= s_last_in_event;
        end
    end

    // Window bookkeeping: evict and append
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_METRICS; i++) begin
                total_reg[i]  <= '0;
                count_reg[i]  <= '0;
                oldest_reg[i] <= '0;
            end
        end else if (state_reg == ST_TR_EVICT) begin
            total_reg[idx]  <= cur_total - TW'($signed(mem_rdata));
            oldest_reg[idx] <= oldest_adv;
            count_reg[idx]  <= cur_count - CW'(1);
        end else if (state_reg == ST_TR_APPEND) begin
            total_reg[idx] <= cur_total + TW'(x_reg);
            count_reg[idx] <= cur_count + CW'(1);
        end
    end

    // Window walk pipeline flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == ST_SC_ACC) && acc_issue;
            v2_reg <= v1_reg;
        end
    end

    // Scoring datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_SC_E: begin
                e_reg      <= dev_abs;
                score_reg  <= 16'd0;
                rd_cnt_reg <= '0;
                slot_reg   <= cur_oldest;
                a_reg      <= '0;
            end
            ST_SC_ACC: begin
                if (acc_issue) begin
                    rd_cnt_reg <= rd_cnt_reg + CW'(1);
                    slot_reg   <= slot_adv;
                end
                if (v2_reg) begin
                    a_reg <= a_reg + AW'(dev_abs);
                end
            end
            ST_SC_TD: begin
                num_reg <= {prod[NW-25:0], 24'd0};
            end
            ST_SC_DEN: begin
                if (sc_special) begin
                    score_reg <= SCORE_ONE;
                end
            end
            ST_SC_DIV: begin
                if (div_st.done && div_st.sat) begin
                    score_reg <= SCORE_ONE;
                end
            end
            ST_SC_TM: begin
                if (quot >= RATIO_SAT) begin
                    score_reg <= SCORE_ONE;
                end
            end
            ST_SC_TF: begin
                score_reg <= t_lo + 16'(t_round >> 14);
            end
            default: begin
                score_reg <= score_reg;
            end
        endcase
    end

    // Event maximum and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_SC_UPD && score_reg > max_reg) begin
                max_reg <= score_reg;
            end
            // Load a new result, or drop the one just taken
            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
                m_score_reg <= max_reg;
                max_reg     <= '0;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    mwmad_ring_mem #(
        .ADDR_W (RAW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (x_reg),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    mwmad_mul #(
        .A_W (MA),
        .B_W (MB)
    ) u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    mwmad_div #(
        .NUM_W (NW),
        .DEN_W (DW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (prod[DW-1:0]),
        .status  (div_st),
        .quot    (quot)
    );

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_anomaly_score = m_score_reg;

`ifndef NO_ASSERTIONS
    // Window fill never passes the store depth while an item is in work
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> 32'(cur_count) <= WINDOW_MAX)
        else $error("window count above depth");

    // A result appears only from the emit step
    a_emit_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

    // Divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        div_st.done |-> state_reg == ST_SC_DIV)
        else $error("divider done out of sequence");

    // Event maximum stays within full scale
    a_max_range: assert property (@(posedge aclk) disable iff (!aresetn)
        max_reg <= SCORE_ONE)
        else $error("event maximum above full scale");
`endif

endmodule
